[rtl/bf_pkg.sv]
// Shared constants, command codes and the round mixing function of the block cipher.
package bf_pkg;

    localparam int CMD_W       = 2;
    localparam int IDX_W       = 11;
    localparam int WORD_W      = 32;

    localparam int TABLE_WORDS = 1042;
    localparam int PKEY_WORDS  = 18;
    localparam int PKEY_AW     = $clog2(PKEY_WORDS);
    localparam int SBOX_BASE   = 18;
    localparam int SBOX_COUNT  = 4;
    localparam int SBOX_DEPTH  = 256;
    localparam int SBOX_AW     = $clog2(SBOX_DEPTH);
    localparam int SBOX_SEL_W  = $clog2(SBOX_COUNT);

    localparam int ROUNDS_DEF  = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCRYPT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECRYPT = 2'd2;

    typedef logic [WORD_W-1:0] t_word;

    // F = ((S0[a] + S1[b]) ^ S2[c]) + S3[d]
    function automatic t_word f_mix(t_word s0, t_word s1, t_word s2, t_word s3);
        return ((s0 + s1) ^ s2) + s3;
    endfunction

endpackage

[rtl/bf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/blowfish_block_cipher.sv]
// Top level of the iterative Feistel block cipher with its loadable key table.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | command, table_index, table_word,
//          |           |                            | block_first, block_second
//  out     | output    | o_out_valid / i_out_ready  | out_first, out_second
//
//  A load beat writes the table when it is accepted. An encrypt or decrypt beat runs ROUNDS
//  rounds: the accept cycle issues the first S-box reads, then one round per cycle runs
//  through the shared mix unit fed by the four S-box RAM read ports.
//  The result lands in an output register; a new beat is taken while it waits.
//  If the result is still waiting when the next one finishes, the last round holds.
//  Reset (synchronous, active low) clears control only; the table is undefined until loaded.
module blowfish_block_cipher #(
    parameter int ROUNDS = bf_pkg::ROUNDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [bf_pkg::CMD_W-1:0]   i_command,
    input  logic [bf_pkg::IDX_W-1:0]   i_table_index,
    input  logic [bf_pkg::WORD_W-1:0]  i_table_word,
    input  logic [bf_pkg::WORD_W-1:0]  i_block_first,
    input  logic [bf_pkg::WORD_W-1:0]  i_block_second,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [bf_pkg::WORD_W-1:0]  o_out_first,
    output logic [bf_pkg::WORD_W-1:0]  o_out_second
);

    import bf_pkg::*;

    localparam int RND_W = $clog2(ROUNDS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // control
    logic               r_state, n_state;
    logic [RND_W-1:0]   r_rnd,   n_rnd;
    logic [PKEY_AW-1:0] r_kidx,  n_kidx;   // key of the next round
    logic               r_dec,   n_dec;
    logic               r_out_valid, n_out_valid;

    // datapath
    t_word r_z, n_z;          // key-mixed half of the current round
    t_word r_y, n_y;          // half that the round's F output is folded into
    t_word r_out_first, n_out_first;
    t_word r_out_second, n_out_second;

    // round keys in flops, S-boxes in RAM
    t_word r_pkey [PKEY_WORDS];

    logic       w_accept, w_cipher, w_load, w_last, w_hold, w_re;
    logic       w_load_pkey, w_load_sbox;
    logic [IDX_W-1:0] w_sbox_off;
    t_word      w_z0, w_f, w_x_new, w_z_next, w_zaddr;
    t_word      w_sdata [SBOX_COUNT];

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cipher   = w_accept && (i_command == CMD_ENCRYPT || i_command == CMD_DECRYPT);
    assign w_load     = w_accept && (i_command == CMD_LOAD);

    assign w_load_pkey = w_load && (i_table_index < IDX_W'(PKEY_WORDS));
    assign w_load_sbox = w_load && (i_table_index >= IDX_W'(SBOX_BASE))
                         && (i_table_index < IDX_W'(TABLE_WORDS));
    assign w_sbox_off  = i_table_index - IDX_W'(SBOX_BASE);

    assign w_last = (r_rnd == RND_W'(ROUNDS - 1));
    // result of the last round cannot leave while the previous one still waits
    assign w_hold = (r_state == ST_RUN) && w_last && r_out_valid && !i_out_ready;

    // first round: key 0 for encrypt, key ROUNDS+1 for decrypt
    assign w_z0 = (i_command == CMD_DECRYPT)
                  ? (r_pkey[PKEY_AW'(ROUNDS + 1)] ^ i_block_second)
                  : (r_pkey[0] ^ i_block_second);

    // shared round unit
    assign w_f      = f_mix(w_sdata[0], w_sdata[1], w_sdata[2], w_sdata[3]);
    assign w_x_new  = w_f ^ r_y;
    assign w_z_next = r_pkey[r_kidx] ^ w_x_new;

    assign w_zaddr = (r_state == ST_IDLE) ? w_z0 : w_z_next;
    assign w_re    = w_cipher || ((r_state == ST_RUN) && !w_last);

    for (genvar g = 0; g < SBOX_COUNT; g++) begin : g_sbox
        bf_ram #(
            .WIDTH (WORD_W),
            .DEPTH (SBOX_DEPTH)
        ) u_sbox (
            .i_clk   (i_clk),
            .i_we    (w_load_sbox && (w_sbox_off[SBOX_AW +: SBOX_SEL_W] == SBOX_SEL_W'(g))),
            .i_waddr (w_sbox_off[SBOX_AW-1:0]),
            .i_wdata (i_table_word),
            .i_re    (w_re),
            .i_raddr (w_zaddr[SBOX_AW*(SBOX_COUNT-1-g) +: SBOX_AW]),
            .o_rdata (w_sdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_load_pkey) begin
            r_pkey[i_table_index[PKEY_AW-1:0]] <= i_table_word;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_rnd        = r_rnd;
        n_kidx       = r_kidx;
        n_dec        = r_dec;
        n_z          = r_z;
        n_y          = r_y;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        unique case (r_state)
            ST_IDLE: begin
                if (w_cipher) begin
                    n_state = ST_RUN;
                    n_rnd   = '0;
                    n_dec   = (i_command == CMD_DECRYPT);
                    n_kidx  = (i_command == CMD_DECRYPT) ? PKEY_AW'(ROUNDS) : PKEY_AW'(1);
                    n_z     = w_z0;
                    n_y     = i_block_first;
                end
            end
            ST_RUN: begin
                if (!w_last) begin
                    n_rnd  = r_rnd + RND_W'(1);
                    n_kidx = r_dec ? (r_kidx - PKEY_AW'(1)) : (r_kidx + PKEY_AW'(1));
                    n_z    = w_z_next;
                    n_y    = r_z;
                end else if (!w_hold) begin
                    // whitening
                    n_state      = ST_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_first  = w_x_new ^ (r_dec ? r_pkey[1] : r_pkey[PKEY_AW'(ROUNDS)]);
                    n_out_second = r_z ^ (r_dec ? r_pkey[0] : r_pkey[PKEY_AW'(ROUNDS + 1)]);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rnd       <= '0;
            r_kidx      <= '0;
            r_dec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rnd       <= n_rnd;
            r_kidx      <= n_kidx;
            r_dec       <= n_dec;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z          <= n_z;
        r_y          <= n_y;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_first  = r_out_first;
    assign o_out_second = r_out_second;

`ifndef SYNTHESIS
    a_cipher_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cipher |=> (r_state == ST_RUN) && (r_rnd == '0))
        else $error("cipher beat did not start the round sequence");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && w_last && !w_hold |=> (r_state == ST_IDLE) && o_out_valid)
        else $error("last round did not deliver a result");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !$rose(o_out_valid) && (r_state == ST_IDLE))
        else $error("load beat produced a result");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_kidx < PKEY_AW'(PKEY_WORDS)))
        else $error("round key index out of range");
`endif

endmodule

[verif/blowfish_block_cipher_tb.sv]
// Self-checking testbench for the Feistel block cipher with its loadable key table.
module blowfish_block_cipher_tb;
    import bf_pkg::*;

    // Command code the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 950;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = ROUNDS_DEF + 4;

    typedef struct packed {
        t_word first;
        t_word second;
    } t_block;

    // Tracks the key table and predicts every cipher result; checks results in order.
    class cipher_tracker;
        t_word  key_words[TABLE_WORDS];
        t_block expected_blocks[$];
        int     failures;

        function new();
            failures = 0;
        endfunction

        function t_word sbox_read(int sel, logic [7:0] byte_val);
            return key_words[SBOX_BASE + sel * SBOX_DEPTH + byte_val];
        endfunction

        function t_word round_mix(t_word z);
            t_word f;
            f = sbox_read(0, z[31:24]) + sbox_read(1, z[23:16]);
            f = f ^ sbox_read(2, z[15:8]);
            f = f + sbox_read(3, z[7:0]);
            return f;
        endfunction

        function t_block run_cipher(bit decrypt, t_block blk);
            t_word  left, right, z;
            int     r, k;
            t_block res;
            left  = blk.first;
            right = blk.second;
            for (r = 0; r < ROUNDS_DEF; r++) begin
                k     = decrypt ? (ROUNDS_DEF + 1 - r) : r;
                z     = key_words[k % TABLE_WORDS] ^ right;
                right = round_mix(z) ^ left;
                left  = z;
            end
            if (decrypt) begin
                res.first  = right ^ key_words[1];
                res.second = left ^ key_words[0];
            end else begin
                res.first  = right ^ key_words[ROUNDS_DEF % TABLE_WORDS];
                res.second = left ^ key_words[(ROUNDS_DEF + 1) % TABLE_WORDS];
            end
            return res;
        endfunction

        function void note_beat(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx, t_word word,
                                t_block blk);
            case (cmd)
                CMD_LOAD: begin
                    if (idx < TABLE_WORDS) key_words[idx] = word;
                end
                CMD_ENCRYPT: expected_blocks.push_back(run_cipher(1'b0, blk));
                CMD_DECRYPT: expected_blocks.push_back(run_cipher(1'b1, blk));
                default: ;
            endcase
        endfunction

        function void check_block(t_word first, t_word second);
            t_block exp_blk;
            if (expected_blocks.size() == 0) begin
                $error("unexpected result beat: out_first %h, out_second %h", first, second);
                failures++;
                return;
            end
            exp_blk = expected_blocks.pop_front();
            if (first !== exp_blk.first) begin
                $error("out_first: expected %h, actual %h", exp_blk.first, first);
                failures++;
            end
            if (second !== exp_blk.second) begin
                $error("out_second: expected %h, actual %h", exp_blk.second, second);
                failures++;
            end
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [CMD_W-1:0]  i_command;
    logic [IDX_W-1:0]  i_table_index;
    t_word             i_table_word;
    t_word             i_block_first;
    t_word             i_block_second;
    logic              o_out_valid;
    logic              i_out_ready;
    t_word             o_out_first;
    t_word             o_out_second;

    // Idle/stall odds in percent, set per phase; hold_left is the long receiver hold-off.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    cipher_tracker tracker = new();

    blowfish_block_cipher #(
        .ROUNDS (ROUNDS_DEF)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_table_index  (i_table_index),
        .i_table_word   (i_table_word),
        .i_block_first  (i_block_first),
        .i_block_second (i_block_second),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: ready moves on falling edges; a pending hold-off wins over random stalls.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result beats are checked at the rising edge that moves them.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            tracker.check_block(o_out_first, o_out_second);
    end

    // Offers one input beat after a random number of idle cycles and waits for the
    // handshake. Valid stays high into the next beat unless an idle cycle comes first.
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx, t_word word,
                             t_block blk);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_command      = cmd;
        i_table_index  = idx;
        i_table_word   = word;
        i_block_first  = blk.first;
        i_block_second = blk.second;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.note_beat(cmd, idx, word, blk);
    endtask

    task automatic load_word(int idx, t_word word);
        send_beat(CMD_LOAD, idx[IDX_W-1:0], word, t_block'(0));
    endtask

    task automatic send_cipher(logic [CMD_W-1:0] cmd, t_block blk);
        send_beat(cmd, IDX_W'($urandom), $urandom, blk);
    endtask

    // Drops valid and waits for every outstanding result, then a few more cycles so a
    // stray result would still be caught.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_phase(int phase);
        case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    initial begin
        int     done;
        int     pick;
        int     phase;
        bit     held;
        bit     paused;
        t_block blk;
        t_block ct;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_LOAD;
        i_table_index  = '0;
        i_table_word   = '0;
        i_block_first  = '0;
        i_block_second = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the whole table first: no cipher beat may touch an unwritten entry.
        set_phase(0);
        for (int i = 0; i < TABLE_WORDS; i++) load_word(i, $urandom);

        // Directed part: index and word extremes, ignored beats, all-zero and all-one
        // blocks, a round trip and a load that a cipher beat uses right away.
        load_word(0, 32'hFFFF_FFFF);
        load_word(PKEY_WORDS - 1, 32'h0000_0000);
        load_word(SBOX_BASE, 32'h0000_0000);
        load_word(TABLE_WORDS - 1, 32'hFFFF_FFFF);
        load_word(TABLE_WORDS, 32'hDEAD_BEEF);                  // out of range: dropped
        send_beat(CMD_LOAD, '1, 32'hFFFF_FFFF, t_block'(0));    // top address: dropped
        send_beat(CMD_UNUSED, '1, '1, '1);                      // unused code: no result
        send_beat(CMD_UNUSED, '0, '0, '0);
        send_cipher(CMD_ENCRYPT, t_block'(0));
        send_cipher(CMD_ENCRYPT, '1);
        send_cipher(CMD_DECRYPT, t_block'(0));
        send_cipher(CMD_DECRYPT, '1);
        blk = {$urandom, $urandom};
        ct  = tracker.run_cipher(1'b0, blk);
        send_cipher(CMD_ENCRYPT, blk);
        send_cipher(CMD_DECRYPT, ct);
        load_word(5, $urandom);
        send_cipher(CMD_ENCRYPT, blk);
        load_word(SBOX_BASE + 3 * SBOX_DEPTH, $urandom);
        send_cipher(CMD_DECRYPT, {$urandom, $urandom});
        drain_results();

        // Random part. Mostly cipher beats and encrypt/decrypt round trips on a table that
        // keeps changing; a few beats the block must ignore.
        done   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (done < RANDOM_BEATS) begin
            phase = done * 4 / RANDOM_BEATS;
            set_phase(phase);

            // Long receiver hold-off with the sender still pushing: fills the pipe.
            if (!held && phase == 0 && done >= 100) begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            // Sender pauses once until everything has come back.
            if (!paused && phase == 2) begin
                paused = 1'b1;
                drain_results();
            end

            pick = $urandom_range(99);
            blk  = {$urandom, $urandom};
            if (pick < 8) begin
                if (pick[0])
                    send_beat(CMD_UNUSED, IDX_W'($urandom), $urandom, blk);
                else
                    send_beat(CMD_LOAD, IDX_W'($urandom_range(2047, TABLE_WORDS)), $urandom,
                              blk);
            end else if (pick < 30) begin
                load_word($urandom_range(TABLE_WORDS - 1, 0), $urandom);
                done++;
            end else if (pick < 45) begin
                ct = tracker.run_cipher(1'b0, blk);
                send_cipher(CMD_ENCRYPT, blk);
                send_cipher(CMD_DECRYPT, ct);
                done += 2;
            end else begin
                send_cipher(pick[0] ? CMD_ENCRYPT : CMD_DECRYPT, blk);
                done++;
            end
        end

        drain_results();
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
